FILE: hdl/cma_pkg.sv
// ----------------------------------------------------------------------------
// cma_pkg
// Shared types and constants of the confusion matrix accumulator.
// ----------------------------------------------------------------------------
package cma_pkg;

  localparam int NUM_CLASSES = 8;
  localparam int IDX_W       = $clog2(NUM_CLASSES);
  localparam int ADDR_W      = 2 * IDX_W;
  localparam int CELLS       = NUM_CLASSES * NUM_CLASSES;
  localparam int CC_W        = 4;
  localparam int LAB_W       = 8;
  localparam int TABLE_W     = 64;
  localparam int CNT_W       = 32;
  localparam int SUM_W       = CNT_W + IDX_W;
  localparam int FRAC_BITS   = 16;
  localparam int FRAC_W      = FRAC_BITS + 1;
  localparam int DVD_W       = CNT_W + FRAC_BITS;
  localparam int STEP_W      = $clog2(DVD_W + 1);

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // input item kind
  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_REPORT = 1'b1;

  // configuration register indexes
  localparam logic REG_CLASS_COUNT = 1'b0;
  localparam logic REG_LABEL_TABLE = 1'b1;

  // result status codes
  localparam logic [1:0] ST_RECORDED  = 2'd0;
  localparam logic [1:0] ST_REJECTED  = 2'd1;
  localparam logic [1:0] ST_REPORT    = 2'd2;
  localparam logic [1:0] ST_EMPTY_ROW = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic in_load;
    logic rd_rec;
    logic rd_rep;
    logic wr_rec;
    logic i_clr;
    logic i_inc;
    logic j_clr;
    logic j_inc;
    logic sum_clr;
    logic sum_acc;
    logic cnt_latch;
    logic div_start_hr;
    logic div_start_cell;
    logic hr_zero;
    logic hr_latch;
    logic fr_latch;
    logic out_rec;
    logic out_cell;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic op_report;
    logic labels_ok;
    logic col_last;
    logic row_last;
    logic total_zero;
    logic tests_zero;
    logic div_done;
    logic div_busy;
    logic out_free;
  } stat_t;

endpackage

FILE: hdl/cma_div.sv
// ----------------------------------------------------------------------------
// cma_div
// Restoring divider, one quotient bit per cycle: (num << 16) / den.
// ----------------------------------------------------------------------------
module cma_div
  import cma_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [CNT_W-1:0]  num,
  input  logic [SUM_W-1:0]  den,
  output logic [FRAC_W-1:0] quo,
  output logic              busy,
  output logic              done
);

  logic [DVD_W-1:0]  dvd;
  logic [SUM_W-1:0]  dsr;
  logic [SUM_W-1:0]  rem;
  logic [STEP_W-1:0] step;
  logic [SUM_W:0]    rem_sh;
  logic [SUM_W:0]    diff;
  logic              fits;

  // one long-division step
  always_comb begin
    rem_sh = {rem, dvd[DVD_W-1]};
    diff   = rem_sh - {1'b0, dsr};
    fits   = rem_sh >= {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        dvd  <= {num, {FRAC_BITS{1'b0}}};
        dsr  <= den;
        rem  <= '0;
        quo  <= '0;
      end else if (busy) begin
        dvd  <= {dvd[DVD_W-2:0], 1'b0};
        rem  <= fits ? diff[SUM_W-1:0] : rem_sh[SUM_W-1:0];
        quo  <= {quo[FRAC_W-2:0], fits};
        step <= step + 1'b1;
        if (step == STEP_W'(DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: hdl/cma_dp.sv
// ----------------------------------------------------------------------------
// cma_dp
// Datapath: config registers, label lookup, cell memory, totals, divider
// and the output register.
// ----------------------------------------------------------------------------
module cma_dp
  import cma_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [TABLE_W-1:0] cfg_data,
  input  logic               in_op,
  input  logic [LAB_W-1:0]   in_true,
  input  logic [LAB_W-1:0]   in_pred,
  input  cmd_t               cmd,
  output stat_t              stat,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic [IDX_W-1:0]   out_row,
  output logic [IDX_W-1:0]   out_col,
  output logic [CNT_W-1:0]   out_cnt,
  output logic [FRAC_W-1:0]  out_frac,
  output logic [FRAC_W-1:0]  out_hr,
  output logic               out_last
);

  logic [CC_W-1:0]    cc_q;
  logic [TABLE_W-1:0] lt_q;
  logic               op_q;
  logic [LAB_W-1:0]   tl_q;
  logic [LAB_W-1:0]   pl_q;
  logic [CNT_W-1:0]   mem [CELLS];
  logic [CELLS-1:0]   vld;
  logic [CNT_W-1:0]   mem_q;
  logic               vld_q;
  logic [CNT_W-1:0]   mem_eff;
  logic [CNT_W-1:0]   inc;
  logic [CNT_W-1:0]   tests;
  logic [CNT_W-1:0]   hits;
  logic [IDX_W-1:0]   i_q;
  logic [IDX_W-1:0]   j_q;
  logic [SUM_W-1:0]   sum_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [FRAC_W-1:0]  hr_q;
  logic [FRAC_W-1:0]  fr_q;
  logic [CC_W-1:0]    n_act;
  logic [IDX_W-1:0]   n_last;
  logic [IDX_W-1:0]   r_idx;
  logic [IDX_W-1:0]   c_idx;
  logic               r_ok;
  logic               c_ok;
  logic [ADDR_W-1:0]  rd_addr;
  logic [ADDR_W-1:0]  wr_addr;
  logic [CNT_W-1:0]   div_num;
  logic [SUM_W-1:0]   div_den;
  logic [FRAC_W-1:0]  div_q;
  logic               div_busy;
  logic               div_done;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cc_q <= CC_W'(NUM_CLASSES);
      lt_q <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CLASS_COUNT: cc_q <= cfg_data[CC_W-1:0];
        REG_LABEL_TABLE: lt_q <= cfg_data;
        default: ;
      endcase
    end
  end

  // active class count, clamped
  always_comb begin
    if (cc_q < CC_W'(2))                n_act = CC_W'(2);
    else if (cc_q > CC_W'(NUM_CLASSES)) n_act = CC_W'(NUM_CLASSES);
    else                                n_act = cc_q;
    n_last = IDX_W'(n_act - 1'b1);
  end

  // label lookup, lowest matching class wins
  always_comb begin
    r_idx = '0;
    c_idx = '0;
    r_ok  = 1'b0;
    c_ok  = 1'b0;
    for (int k = NUM_CLASSES - 1; k >= 0; k--) begin
      if (CC_W'(k) < n_act && lt_q[LAB_W*k +: LAB_W] == tl_q) begin
        r_idx = IDX_W'(k);
        r_ok  = 1'b1;
      end
      if (CC_W'(k) < n_act && lt_q[LAB_W*k +: LAB_W] == pl_q) begin
        c_idx = IDX_W'(k);
        c_ok  = 1'b1;
      end
    end
  end

  // input capture
  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      op_q <= in_op;
      tl_q <= in_true;
      pl_q <= in_pred;
    end
  end

  assign wr_addr = {r_idx, c_idx};
  assign rd_addr = cmd.rd_rep ? {i_q, j_q} : wr_addr;

  // cell memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.rd_rec || cmd.rd_rep) mem_q <= mem[rd_addr];
    if (cmd.wr_rec) mem[wr_addr] <= inc;
  end

  // per-cell valid bits, never-written cells read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      vld_q <= 1'b0;
    end else begin
      if (cmd.rd_rec || cmd.rd_rep) vld_q <= vld[rd_addr];
      if (cmd.wr_rec) vld[wr_addr] <= 1'b1;
    end
  end

  assign mem_eff = vld_q ? mem_q : '0;
  assign inc     = (mem_eff == CNT_MAX) ? mem_eff : mem_eff + 1'b1;

  // test and hit totals, saturating
  always_ff @(posedge clk) begin
    if (rst) begin
      tests <= '0;
      hits  <= '0;
    end else if (cmd.wr_rec) begin
      if (tests != CNT_MAX) tests <= tests + 1'b1;
      if (tl_q == pl_q && hits != CNT_MAX) hits <= hits + 1'b1;
    end
  end

  // report walk counters and row sum
  always_ff @(posedge clk) begin
    if (cmd.i_clr)      i_q <= '0;
    else if (cmd.i_inc) i_q <= i_q + 1'b1;
    if (cmd.j_clr)      j_q <= '0;
    else if (cmd.j_inc) j_q <= j_q + 1'b1;
    if (cmd.sum_clr)      sum_q <= '0;
    else if (cmd.sum_acc) sum_q <= sum_q + SUM_W'(mem_eff);
    if (cmd.cnt_latch) begin
      cnt_q <= mem_eff;
      fr_q  <= '0;
    end else if (cmd.fr_latch) begin
      fr_q <= div_q;
    end
    if (cmd.hr_zero)       hr_q <= '0;
    else if (cmd.hr_latch) hr_q <= div_q;
  end

  // shared divider
  assign div_num = cmd.div_start_hr ? hits : mem_eff;
  assign div_den = cmd.div_start_hr ? SUM_W'(tests) : sum_q;

  cma_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start_hr | cmd.div_start_cell),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_q),
    .busy  (div_busy),
    .done  (div_done)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_rec || cmd.out_cell) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_rec) begin
      out_status <= (r_ok && c_ok) ? ST_RECORDED : ST_REJECTED;
      out_row    <= r_idx;
      out_col    <= c_idx;
      out_cnt    <= (r_ok && c_ok) ? inc : '0;
      out_frac   <= '0;
      out_hr     <= '0;
      out_last   <= 1'b1;
    end else if (cmd.out_cell) begin
      out_status <= (sum_q == '0) ? ST_EMPTY_ROW : ST_REPORT;
      out_row    <= i_q;
      out_col    <= j_q;
      out_cnt    <= cnt_q;
      out_frac   <= fr_q;
      out_hr     <= hr_q;
      out_last   <= (i_q == n_last) && (j_q == n_last);
    end
  end

  // status to controller
  always_comb begin
    stat.op_report  = (op_q == OP_REPORT);
    stat.labels_ok  = r_ok && c_ok;
    stat.col_last   = (j_q == n_last);
    stat.row_last   = (i_q == n_last);
    stat.total_zero = (sum_q == '0);
    stat.tests_zero = (tests == '0);
    stat.div_done   = div_done;
    stat.div_busy   = div_busy;
    stat.out_free   = !out_valid || out_ready;
  end

endmodule

FILE: hdl/cma_ctrl.sv
// ----------------------------------------------------------------------------
// cma_ctrl
// Controller: sequences record and report items over the datapath.
// ----------------------------------------------------------------------------
module cma_ctrl
  import cma_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_REJ, S_REC_RD, S_REC_WR, S_HR_WAIT, S_ROW,
    S_SUM_ADDR, S_SUM_ACC, S_CELL_ADDR, S_CELL_DATA, S_CELL_DIV, S_CELL_OUT
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.in_load = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.op_report) begin
          cmd.i_clr = 1'b1;
          if (stat.tests_zero) begin
            cmd.hr_zero = 1'b1;
            state_next  = S_ROW;
          end else begin
            cmd.div_start_hr = 1'b1;
            state_next       = S_HR_WAIT;
          end
        end else if (!stat.labels_ok) begin
          state_next = S_REJ;
        end else begin
          cmd.rd_rec = 1'b1;
          state_next = S_REC_RD;
        end
      end
      S_REJ: begin
        if (stat.out_free) begin
          cmd.out_rec = 1'b1;
          state_next  = S_IDLE;
        end
      end
      S_REC_RD: state_next = S_REC_WR;
      S_REC_WR: begin
        if (stat.out_free) begin
          cmd.wr_rec  = 1'b1;
          cmd.out_rec = 1'b1;
          state_next  = S_IDLE;
        end
      end
      S_HR_WAIT: begin
        if (stat.div_done) begin
          cmd.hr_latch = 1'b1;
          state_next   = S_ROW;
        end
      end
      S_ROW: begin
        cmd.sum_clr = 1'b1;
        cmd.j_clr   = 1'b1;
        state_next  = S_SUM_ADDR;
      end
      S_SUM_ADDR: begin
        cmd.rd_rep = 1'b1;
        state_next = S_SUM_ACC;
      end
      S_SUM_ACC: begin
        cmd.sum_acc = 1'b1;
        if (stat.col_last) begin
          cmd.j_clr  = 1'b1;
          state_next = S_CELL_ADDR;
        end else begin
          cmd.j_inc  = 1'b1;
          state_next = S_SUM_ADDR;
        end
      end
      S_CELL_ADDR: begin
        cmd.rd_rep = 1'b1;
        state_next = S_CELL_DATA;
      end
      S_CELL_DATA: begin
        cmd.cnt_latch = 1'b1;
        if (stat.total_zero) begin
          state_next = S_CELL_OUT;
        end else begin
          cmd.div_start_cell = 1'b1;
          state_next         = S_CELL_DIV;
        end
      end
      S_CELL_DIV: begin
        if (stat.div_done) begin
          cmd.fr_latch = 1'b1;
          state_next   = S_CELL_OUT;
        end
      end
      S_CELL_OUT: begin
        if (stat.out_free) begin
          cmd.out_cell = 1'b1;
          if (!stat.col_last) begin
            cmd.j_inc  = 1'b1;
            state_next = S_CELL_ADDR;
          end else if (stat.row_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.i_inc  = 1'b1;
            state_next = S_ROW;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

endmodule

FILE: hdl/confusion_matrix_accumulator.sv
// ----------------------------------------------------------------------------
// confusion_matrix_accumulator
// Accumulates a classifier confusion matrix and reports it cell by cell.
//
// Input stream s_*: s_tuser selects record (0) or report (1); s_tdata holds
// the true and predicted labels. Labels map to classes through label_table.
// Output stream m_*: one item per record, n*n items per report (row by row),
// m_tlast on the final one. Config port cfg_* writes class_count (index 0)
// and label_table (index 1); the user must write them only while the block
// is idle, as the block itself does not enforce it. One item is in work at
// a time. A record goes through lookup, memory read and write; a rejected
// record skips the memory read and write. A report computes the hit rate
// (zero without tests), then for each row sums the row and for each cell of
// it divides the count by the row sum in the bit-serial 48-step divider; a
// cell of an empty row skips the divide.
// When the receiver stalls the output register holds its item and the
// controller waits; a finished item waits in that register while the next
// input item is accepted. Reset clears the matrix (per-cell valid bits),
// totals and label_table and sets class_count to 8 at once; no clearing pass.
// ----------------------------------------------------------------------------
module confusion_matrix_accumulator
  import cma_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [TABLE_W-1:0] cfg_data,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [15:0]        s_tdata,  // true_label[7:0], predicted_label[15:8]
  input  logic               s_tuser,  // operation[0]
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [71:0]        m_tdata,  // row_index[2:0], col_index[5:3],
                                       // cell_count[37:6], cell_fraction[54:38],
                                       // hit_rate[71:55]
  output logic [1:0]         m_tuser,  // status[1:0]
  output logic               m_tlast
);

  cmd_t               cmd;
  stat_t              stat;
  logic [IDX_W-1:0]   out_row;
  logic [IDX_W-1:0]   out_col;
  logic [CNT_W-1:0]   out_cnt;
  logic [FRAC_W-1:0]  out_frac;
  logic [FRAC_W-1:0]  out_hr;

  cma_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cma_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_op      (s_tuser),
    .in_true    (s_tdata[7:0]),
    .in_pred    (s_tdata[15:8]),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (m_tuser),
    .out_row    (out_row),
    .out_col    (out_col),
    .out_cnt    (out_cnt),
    .out_frac   (out_frac),
    .out_hr     (out_hr),
    .out_last   (m_tlast)
  );

  assign m_tdata = {out_hr, out_frac, out_cnt, out_col, out_row};

  // divider never runs while a new item can be taken
  a_idle_div : assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !stat.div_busy)
    else $error("divider busy while accepting input");

  // a rejected record carries no count and ends its item
  a_reject : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == ST_REJECTED) |-> (out_cnt == '0 && m_tlast))
    else $error("rejected item with nonzero count");

  // shares never exceed one
  a_frac : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_frac <= FRAC_W'(1 << FRAC_BITS) &&
                  out_hr <= FRAC_W'(1 << FRAC_BITS)))
    else $error("fraction above one");

  // a record result is always the last of its item
  a_rec_last : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == ST_RECORDED) |-> m_tlast)
    else $error("record result without last");

endmodule
